// ===== sv/dkl_pkg.sv =====
// Shared command codes, status codes and types for the dual-key lookup table.
package dkl_pkg;

  localparam logic [2:0] CMD_INSERT        = 3'd0;
  localparam logic [2:0] CMD_LOOKUP_FIRST  = 3'd1;
  localparam logic [2:0] CMD_LOOKUP_SECOND = 3'd2;
  localparam logic [2:0] CMD_REMOVE_FIRST  = 3'd3;
  localparam logic [2:0] CMD_REMOVE_SECOND = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic use_first;
    logic use_second;
  } key_sel_t;

endpackage

// ===== sv/dkl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module dkl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dkl_match.sv =====
// Shared key comparator used by the table scan.
module dkl_match import dkl_pkg::*; #(
  parameter int FIRST_KEY_BITS  = 32,
  parameter int SECOND_KEY_BITS = 32
) (
  input  key_sel_t                   sel,
  input  logic [FIRST_KEY_BITS-1:0]  want_first,
  input  logic [FIRST_KEY_BITS-1:0]  stored_first,
  input  logic [SECOND_KEY_BITS-1:0] want_second,
  input  logic [SECOND_KEY_BITS-1:0] stored_second,
  output logic                       hit
);

  assign hit = (sel.use_first && (want_first == stored_first)) ||
               (sel.use_second && (want_second == stored_second));

endmodule

// ===== sv/dual_key_lookup_table_top.sv =====
// Top level of the dual-key lookup table: sequencer, entry stores and scan.
//
// A command beat is taken when start is high and busy is low. The command
// selects insert, lookup by first or second key, or removal by either key.
// Entries are kept densely in insertion order; a removal moves every later
// entry down one place. Each command gives exactly one result beat: done is
// high for one cycle with status, position, found_data and entries_used.
// The receiver cannot stall, so a result is never held back.
// An unknown command code is answered without a scan. A lookup or insert
// scans the stored entries in order and stops at the first match; a removal
// then moves every later entry down for compaction. The scan and the move
// share the single read port of the entry stores, reading it once per cycle.
// Busy rises after the start beat of a known command and is low again in the cycle of the result beat.
// Reset empties the table at once; stored entries need no clearing.
module dual_key_lookup_table_top import dkl_pkg::*; #(
  parameter int DEPTH           = 16,
  parameter int FIRST_KEY_BITS  = 32,
  parameter int SECOND_KEY_BITS = 32,
  parameter int DATA_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  command,
  input  logic [31:0] first_key,
  input  logic [31:0] second_key,
  input  logic [31:0] entry_data,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  position,
  output logic [31:0] found_data,
  output logic [4:0]  entries_used
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]                 state;
  logic [2:0]                 cmd;
  logic [FIRST_KEY_BITS-1:0]  key1;
  logic [SECOND_KEY_BITS-1:0] key2;
  logic [DATA_BITS-1:0]       dat;
  logic [CW-1:0]              count;
  logic [CW-1:0]              issue_idx;
  logic [AW-1:0]              cmp_idx;
  logic                       cmp_valid;
  logic [CW-1:0]              shift_idx;
  logic [AW-1:0]              wr_idx;
  logic                       wr_pending;
  logic [AW-1:0]              hit_pos;
  logic [DATA_BITS-1:0]       hit_data;
  logic                       done_next;

  logic                       is_insert;
  logic                       is_remove;
  logic                       by_first;
  key_sel_t                   sel;
  logic                       key_hit;
  logic                       hit;
  logic                       at_end;
  logic                       full;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [DATA_BITS-1:0]       wdata_d;
  logic [FIRST_KEY_BITS-1:0]  wdata_k1;
  logic [SECOND_KEY_BITS-1:0] wdata_k2;
  logic [DATA_BITS-1:0]       rd_d;
  logic [FIRST_KEY_BITS-1:0]  rd_k1;
  logic [SECOND_KEY_BITS-1:0] rd_k2;

  assign busy = (state != ST_IDLE);

  assign is_insert = (cmd == CMD_INSERT);
  assign is_remove = (cmd == CMD_REMOVE_FIRST) || (cmd == CMD_REMOVE_SECOND);
  assign by_first  = (cmd == CMD_LOOKUP_FIRST) || (cmd == CMD_REMOVE_FIRST);

  assign sel.use_first  = is_insert || by_first;
  assign sel.use_second = is_insert || !by_first;

  assign hit    = cmp_valid && key_hit;
  assign at_end = (issue_idx == count);
  assign full   = (count == CW'(DEPTH));

  assign ram_raddr = (state == ST_SHIFT) ? shift_idx[AW-1:0] : issue_idx[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    wdata_d   = rd_d;
    wdata_k1  = rd_k1;
    wdata_k2  = rd_k2;
    if (state == ST_SCAN && !hit && at_end && is_insert && !full) begin
      ram_we    = 1'b1;
      ram_waddr = count[AW-1:0];
      wdata_d   = dat;
      wdata_k1  = key1;
      wdata_k2  = key2;
    end else if (state == ST_SHIFT) begin
      ram_we = wr_pending;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:  done_next = start && (command > CMD_REMOVE_SECOND);
      ST_SCAN:  done_next = hit ? !is_remove : at_end;
      ST_SHIFT: done_next = !(shift_idx < count);
      default:  done_next = 1'b0;
    endcase
  end

  dkl_match #(
    .FIRST_KEY_BITS (FIRST_KEY_BITS),
    .SECOND_KEY_BITS(SECOND_KEY_BITS)
  ) u_match (
    .sel          (sel),
    .want_first   (key1),
    .stored_first (rd_k1),
    .want_second  (key2),
    .stored_second(rd_k2),
    .hit          (key_hit)
  );

  dkl_ram #(.WIDTH(DATA_BITS), .DEPTH(DEPTH)) u_data_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wdata_d),
    .raddr(ram_raddr), .rdata(rd_d)
  );

  dkl_ram #(.WIDTH(FIRST_KEY_BITS), .DEPTH(DEPTH)) u_first_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wdata_k1),
    .raddr(ram_raddr), .rdata(rd_k1)
  );

  dkl_ram #(.WIDTH(SECOND_KEY_BITS), .DEPTH(DEPTH)) u_second_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wdata_k2),
    .raddr(ram_raddr), .rdata(rd_k2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      cmp_valid  <= 1'b0;
      wr_pending <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd        <= command;
            key1       <= FIRST_KEY_BITS'(first_key);
            key2       <= SECOND_KEY_BITS'(second_key);
            dat        <= DATA_BITS'(entry_data);
            issue_idx  <= '0;
            cmp_valid  <= 1'b0;
            if (command > CMD_REMOVE_SECOND) begin
              status       <= STATUS_OK;
              position     <= '0;
              found_data   <= '0;
              entries_used <= 5'(count);
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          priority if (hit) begin
            cmp_valid <= 1'b0;
            if (is_insert) begin
              status       <= STATUS_DUPLICATE;
              position     <= '0;
              found_data   <= '0;
              entries_used <= 5'(count);
              state        <= ST_IDLE;
            end else if (is_remove) begin
              hit_pos    <= cmp_idx;
              hit_data   <= rd_d;
              shift_idx  <= CW'(cmp_idx) + CW'(1);
              wr_pending <= 1'b0;
              state      <= ST_SHIFT;
            end else begin
              status       <= STATUS_OK;
              position     <= 4'(cmp_idx);
              found_data   <= 32'(rd_d);
              entries_used <= 5'(count);
              state        <= ST_IDLE;
            end
          end else if (at_end) begin
            cmp_valid  <= 1'b0;
            found_data <= '0;
            state      <= ST_IDLE;
            if (!is_insert) begin
              status       <= STATUS_NOT_FOUND;
              position     <= '0;
              entries_used <= 5'(count);
            end else if (full) begin
              status       <= STATUS_FULL;
              position     <= '0;
              entries_used <= 5'(count);
            end else begin
              status       <= STATUS_OK;
              position     <= 4'(count);
              count        <= count + CW'(1);
              entries_used <= 5'(count + CW'(1));
            end
          end else begin
            cmp_idx   <= issue_idx[AW-1:0];
            cmp_valid <= 1'b1;
            issue_idx <= issue_idx + CW'(1);
          end
        end
        ST_SHIFT: begin
          if (shift_idx < count) begin
            wr_idx     <= AW'(shift_idx - CW'(1));
            wr_pending <= 1'b1;
            shift_idx  <= shift_idx + CW'(1);
          end else begin
            wr_pending   <= 1'b0;
            count        <= count - CW'(1);
            status       <= STATUS_OK;
            position     <= 4'(hit_pos);
            found_data   <= 32'(hit_data);
            entries_used <= 5'(count - CW'(1));
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (position == '0 && found_data == '0))
    else $error("failed command reports a position or data");

  a_start_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither worked on nor answered");

  a_move_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && wr_pending) |-> (CW'(wr_idx) < count))
    else $error("compaction writes beyond the stored entries");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the dual-key lookup table: directed and random command beats.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dkl_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int POOL_SIZE = 24;
  localparam logic [2:0] CMD_UNUSED_LOW  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HIGH = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  position;
    logic [31:0] found_data;
    logic [4:0]  entries_used;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  command = '0;
  logic [31:0] first_key = '0;
  logic [31:0] second_key = '0;
  logic [31:0] entry_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  position;
  logic [31:0] found_data;
  logic [4:0]  entries_used;

  logic [31:0] model_data   [TABLE_DEPTH];
  logic [31:0] model_first  [TABLE_DEPTH];
  logic [31:0] model_second [TABLE_DEPTH];
  int          model_count = 0;

  table_result_t pending_results[$];
  logic [31:0]   key_pool [POOL_SIZE];
  int            idle_pct = 19;
  int            error_count = 0;
  int            result_index = 0;

  dual_key_lookup_table_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .first_key    (first_key),
    .second_key   (second_key),
    .entry_data   (entry_data),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .position     (position),
    .found_data   (found_data),
    .entries_used (entries_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int locate_key(bit by_first, logic [31:0] key);
    for (int i = 0; i < model_count; i++) begin
      if ((by_first ? model_first[i] : model_second[i]) == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic table_result_t table_model_apply(logic [2:0] cmd, logic [31:0] k1,
                                                      logic [31:0] k2, logic [31:0] d);
    table_result_t r;
    int at;
    bit by_first;
    r = '0;
    r.status = STATUS_OK;
    case (cmd)
      CMD_INSERT: begin
        if (locate_key(1'b1, k1) >= 0 || locate_key(1'b0, k2) >= 0) begin
          r.status = STATUS_DUPLICATE;
        end else if (model_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          model_data[model_count]   = d;
          model_first[model_count]  = k1;
          model_second[model_count] = k2;
          r.position = 4'(model_count);
          model_count++;
        end
      end
      CMD_LOOKUP_FIRST, CMD_LOOKUP_SECOND, CMD_REMOVE_FIRST, CMD_REMOVE_SECOND: begin
        by_first = (cmd == CMD_LOOKUP_FIRST || cmd == CMD_REMOVE_FIRST);
        at = locate_key(by_first, by_first ? k1 : k2);
        if (at < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.position = 4'(at);
          r.found_data = model_data[at];
          if (cmd == CMD_REMOVE_FIRST || cmd == CMD_REMOVE_SECOND) begin
            for (int i = at; i + 1 < model_count; i++) begin
              model_data[i]   = model_data[i + 1];
              model_first[i]  = model_first[i + 1];
              model_second[i] = model_second[i + 1];
            end
            model_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.entries_used = 5'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < 50) begin
      $display("tb: mismatch at result %0d: %s", result_index, msg);
    end
    error_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    end
  endtask

  // Start is left high after a beat is taken; the next call either changes the
  // fields at once or lowers start for an idle gap.
  task automatic issue_command(logic [2:0] cmd, logic [31:0] k1, logic [31:0] k2,
                               logic [31:0] d);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    first_key  <= k1;
    second_key <= k2;
    entry_data <= d;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(table_model_apply(cmd, k1, k2, d));
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : 32'($urandom);
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        compare_field("status", status, want.status);
        compare_field("position", position, want.position);
        compare_field("found_data", found_data, want.found_data);
        compare_field("entries_used", entries_used, want.entries_used);
      end
      result_index++;
    end
  end

  task automatic test_empty_table();
    issue_command(CMD_LOOKUP_FIRST, '0, '0, '0);
    issue_command(CMD_REMOVE_SECOND, '1, '1, '1);
    issue_command(CMD_UNUSED_LOW, '0, '0, '0);
    issue_command(CMD_UNUSED_HIGH, '1, '1, '1);
  endtask

  task automatic test_fill_to_full();
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] d;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      k1 = (i == 0) ? '0 : (i == TABLE_DEPTH - 1) ? '1 : 32'($urandom);
      k2 = (i == 0) ? '1 : (i == TABLE_DEPTH - 1) ? '0 : 32'($urandom);
      d  = (i == 0) ? '0 : (i == TABLE_DEPTH - 1) ? '1 : 32'($urandom);
      issue_command(CMD_INSERT, k1, k2, d);
    end
    issue_command(CMD_INSERT, $urandom, $urandom, $urandom);
    // With the table full, a duplicate key must still be reported as such.
    issue_command(CMD_INSERT, '0, $urandom, $urandom);
    issue_command(CMD_INSERT, $urandom, '0, $urandom);
  endtask

  task automatic test_lookup_and_remove();
    issue_command(CMD_LOOKUP_FIRST, '1, $urandom, $urandom);
    issue_command(CMD_LOOKUP_SECOND, $urandom, '0, $urandom);
    issue_command(CMD_REMOVE_FIRST, '0, $urandom, $urandom);
    issue_command(CMD_REMOVE_SECOND, $urandom, '0, $urandom);
    issue_command(CMD_LOOKUP_FIRST, '0, $urandom, $urandom);
    issue_command(CMD_REMOVE_FIRST, '1, $urandom, $urandom);
  endtask

  // Phases alternate between filling and draining so that the table passes
  // through every level, full included; one phase runs with no idle gaps.
  task automatic test_random_traffic();
    logic [2:0]  cmd;
    logic [31:0] k1;
    logic [31:0] k2;
    int          insert_pct;
    int          roll;
    int          idx;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct   = (phase == 2) ? 0 : 19;
      insert_pct = (phase % 2 == 0) ? 65 : 30;
      repeat (200) begin
        roll = $urandom_range(0, 99);
        k1 = pick_key();
        k2 = pick_key();
        if (roll < insert_pct) begin
          cmd = CMD_INSERT;
        end else if (roll >= 96) begin
          cmd = 3'($urandom_range(CMD_UNUSED_LOW, CMD_UNUSED_HIGH));
        end else begin
          case ($urandom_range(0, 3))
            0: cmd = CMD_LOOKUP_FIRST;
            1: cmd = CMD_LOOKUP_SECOND;
            2: cmd = CMD_REMOVE_FIRST;
            default: cmd = CMD_REMOVE_SECOND;
          endcase
          if (model_count > 0 && $urandom_range(0, 99) < 80) begin
            idx = $urandom_range(0, model_count - 1);
            k1 = model_first[idx];
            k2 = model_second[idx];
          end
        end
        issue_command(cmd, k1, k2, $urandom);
      end
    end
    idle_pct = 19;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_fill_to_full();
    test_lookup_and_remove();
    test_random_traffic();
    start <= 1'b0;
    for (int n = 0; n < 5000 && pending_results.size() != 0; n++) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== dual_key_lookup_table_top.f =====
sv/dkl_pkg.sv
sv/dkl_ram.sv
sv/dkl_match.sv
sv/dual_key_lookup_table_top.sv
tb/tb.sv
